// ----- rtl/core/tbpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt balance PD bridge drive package
// Shared widths, register indexes, controller commands and the CORDIC table.
// ----------------------------------------------------------------------------
package tbpd_pkg;

    localparam int TABLE_LEN  = 24;
    localparam int TILT_SAT   = 18000;
    localparam int W_OLD      = 64225;
    localparam int W_NEW      = 1311;
    localparam int CORDIC_W   = 30;
    localparam int ACC_W      = 28;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_TILT_LIMIT   = 6000;
    localparam int DEF_DRIVE_LIMIT  = 50;

    // Configuration register indexes
    localparam logic [2:0] REG_TILT_DIV  = 3'd0;
    localparam logic [2:0] REG_RATE_DIV  = 3'd1;
    localparam logic [2:0] REG_OFFSET    = 3'd2;
    localparam logic [2:0] REG_PWM_FULL  = 3'd3;
    localparam logic [2:0] REG_PWM_STEP  = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the sample, set up CORDIC
        logic rotate;    // one CORDIC iteration
        logic filter;    // filter multiply stage
        logic fuse;      // filter sum and tilt
        logic div_start; // start the P and D divisions
        logic div_step;  // one restoring division step
        logic pd;        // form and saturate the drive
        logic bridge;    // compare values
    } tbpd_cmd_t;

    // Rounded atan(2^-i) in units of 1/65536 degree
    function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ACC_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 28'sd2949120;
                5'd1:  v = 28'sd1740967;
                5'd2:  v = 28'sd919879;
                5'd3:  v = 28'sd466945;
                5'd4:  v = 28'sd234379;
                5'd5:  v = 28'sd117304;
                5'd6:  v = 28'sd58666;
                5'd7:  v = 28'sd29335;
                5'd8:  v = 28'sd14668;
                5'd9:  v = 28'sd7334;
                5'd10: v = 28'sd3667;
                5'd11: v = 28'sd1833;
                5'd12: v = 28'sd917;
                5'd13: v = 28'sd458;
                5'd14: v = 28'sd229;
                5'd15: v = 28'sd115;
                5'd16: v = 28'sd57;
                5'd17: v = 28'sd29;
                5'd18: v = 28'sd14;
                5'd19: v = 28'sd7;
                5'd20: v = 28'sd4;
                5'd21: v = 28'sd2;
                5'd22: v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/tbpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tilt balance controller sequencer
// Steps one sample through load, CORDIC, filter, division, PD and bridge.
// ----------------------------------------------------------------------------
module tbpd_ctrl import tbpd_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output tbpd_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ROT, S_FILT, S_FUSE, S_DSTART, S_DIV, S_PD, S_BRIDGE, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] count_reg, count_next;
    logic       out_valid_reg, out_valid_next;

    // Input is taken in idle; output register is cleared when taken
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rotate = 1'b1;
                count_next = count_reg + 5'd1;
                if (count_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                cmd.filter = 1'b1;
                state_next = S_FUSE;
            end
            S_FUSE:
            begin
                cmd.fuse   = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                count_next    = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 5'd1;
                if (count_reg == 5'd22)
                begin
                    state_next = S_PD;
                end
            end
            S_PD:
            begin
                cmd.pd     = 1'b1;
                state_next = S_BRIDGE;
            end
            S_BRIDGE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.bridge     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/tbpd_datapath.sv -----
// ----------------------------------------------------------------------------
// Tilt balance datapath
// CORDIC angle, complementary filter, serial dividers, PD law and bridge.
// ----------------------------------------------------------------------------
module tbpd_datapath import tbpd_pkg::*; #(
    parameter int TILT_LIMIT  = DEF_TILT_LIMIT,
    parameter int DRIVE_LIMIT = DEF_DRIVE_LIMIT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tbpd_cmd_t          cmd,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_y,
    input  logic        [15:0] tilt_div,
    input  logic        [15:0] rate_div,
    input  logic signed [10:0] offset,
    input  logic        [15:0] pwm_full,
    input  logic        [10:0] pwm_step,
    output logic signed [15:0] tilt_hundredths,
    output logic signed [22:0] tilt_rate,
    output logic signed [6:0]  drive,
    output logic        [15:0] compare_a,
    output logic        [15:0] compare_b,
    output logic               forward,
    output logic               bridge_awake
);

    localparam int LIM_C = (DRIVE_LIMIT > 63) ? 63 : DRIVE_LIMIT;
    localparam logic signed [23:0] DRV_LIM = 24'(LIM_C);

    // CORDIC registers
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [ACC_W-1:0]    z_reg;
    logic [4:0]                 it_reg;
    logic                       zero_reg;
    logic signed [12:0]         ginc_reg;

    // Filter and state
    logic signed [31:0] fang_reg;
    logic signed [15:0] prev_reg;
    logic signed [50:0] prod_old_reg;
    logic signed [50:0] prod_new_reg;
    logic signed [15:0] tilt_reg;
    logic signed [22:0] rate_reg;

    // Divider registers: magnitudes divided, signs kept
    logic [22:0] pnum_reg, dnum_reg;
    logic [15:0] prem_reg, drem_reg;
    logic [15:0] pdiv_reg, ddiv_reg;
    logic        pneg_reg, dneg_reg;

    logic signed [6:0]  drive_reg;
    logic        [15:0] ca_reg, cb_reg;

    // CORDIC step
    logic signed [CORDIC_W-1:0] x_sh, y_sh, x_in, y_in;
    logic signed [ACC_W-1:0]    z_in;
    always_comb
    begin
        x_in = CORDIC_W'(accel_x) <<< 8;
        y_in = CORDIC_W'(accel_z) <<< 8;
        z_in = '0;
        if (accel_x < 0)
        begin
            x_in = -x_in;
            y_in = -y_in;
            z_in = (accel_z >= 0) ? 28'sd11796480 : -28'sd11796480;
        end
        x_sh = x_reg >>> it_reg;
        y_sh = y_reg >>> it_reg;
    end

    // Gyro increment: the magnitude is divided by ten with a reciprocal
    // multiply, which is exact over the whole 16-bit range, then re-signed.
    logic [15:0] gabs;
    logic [31:0] gprod;
    logic [12:0] gquo;
    always_comb
    begin
        gabs  = gyro_y[15] ? 16'(-gyro_y) : 16'(gyro_y);
        gprod = 32'(gabs) * 32'd52429;
        gquo  = gprod[31:19];
    end

    // Filter input: Q8 accel tilt and the old-weight term
    logic signed [ACC_W+5:0] atilt_w;
    logic signed [25:0]      atilt;
    logic signed [33:0]      fsum;
    always_comb
    begin
        atilt_w = (34'(z_reg) * 34'sd25) >>> 6;
        atilt   = zero_reg ? 26'sd0 : 26'(atilt_w);
        fsum    = 34'(fang_reg) + (34'(ginc_reg) <<< 8);
    end

    // Tilt from filtered angle, truncated toward zero and saturated
    logic signed [31:0] fnew;
    logic signed [23:0] tq;
    logic signed [23:0] tsat;
    logic signed [51:0] psum;
    always_comb
    begin
        psum = 52'(prod_old_reg) + 52'(prod_new_reg);
        fnew = 32'(psum >>> 16);
        tq   = 24'((fnew + ((fnew < 0) ? 32'sd255 : 32'sd0)) >>> 8);
        if (tq > 24'sd18000)
        begin
            tsat = 24'sd18000;
        end
        else if (tq < -24'sd18000)
        begin
            tsat = -24'sd18000;
        end
        else
        begin
            tsat = tq;
        end
    end

    // Restoring division steps
    logic [16:0] ptry, dtry;
    always_comb
    begin
        ptry = {prem_reg, pnum_reg[22]} - {1'b0, pdiv_reg};
        dtry = {drem_reg, dnum_reg[22]} - {1'b0, ddiv_reg};
    end

    // PD law
    logic signed [23:0] pq, dq, cmdv, cmdsat;
    logic        [15:0] tabs;
    logic        [6:0]  mag;
    logic        [17:0] dec;
    logic signed [18:0] red;
    always_comb
    begin
        pq   = pneg_reg ? -$signed({1'b0, pnum_reg}) : $signed({1'b0, pnum_reg});
        dq   = dneg_reg ? -$signed({1'b0, dnum_reg}) : $signed({1'b0, dnum_reg});
        tabs = tilt_reg[15] ? 16'(-tilt_reg) : 16'(tilt_reg);
        if (32'(tabs) < 32'(TILT_LIMIT))
        begin
            cmdv = pq - dq - 24'(offset);
        end
        else
        begin
            cmdv = '0;
        end
        if (cmdv > DRV_LIM)
        begin
            cmdsat = DRV_LIM;
        end
        else if (cmdv < -DRV_LIM)
        begin
            cmdsat = -DRV_LIM;
        end
        else
        begin
            cmdsat = cmdv;
        end
        mag = drive_reg[6] ? 7'(-drive_reg) : 7'(drive_reg);
        dec = 18'(pwm_step) * 18'(mag);
        red = $signed({3'b0, pwm_full}) - $signed({1'b0, dec});
    end

    // State that reset must clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fang_reg <= '0;
            prev_reg <= '0;
        end
        else if (cmd.fuse)
        begin
            fang_reg <= fnew;
            prev_reg <= 16'(tsat);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
            it_reg   <= '0;
            zero_reg <= (accel_x == 0) && (accel_z == 0);
            ginc_reg <= gyro_y[15] ? 13'(-gquo) : gquo;
        end
        if (cmd.rotate)
        begin
            it_reg <= it_reg + 5'd1;
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_entry(it_reg);
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_entry(it_reg);
            end
        end
        if (cmd.filter)
        begin
            prod_old_reg <= 51'(fsum) * 51'sd64225;
            prod_new_reg <= 51'(atilt) * 51'sd1311;
        end
        if (cmd.fuse)
        begin
            tilt_reg <= 16'(tsat);
            rate_reg <= 23'((tsat - 24'(prev_reg)) * 24'sd100);
        end
        if (cmd.div_start)
        begin
            pnum_reg <= 23'(tilt_reg[15] ? 16'(-tilt_reg) : 16'(tilt_reg));
            pneg_reg <= tilt_reg[15];
            dnum_reg <= rate_reg[22] ? 23'(-rate_reg) : 23'(rate_reg);
            dneg_reg <= rate_reg[22];
            prem_reg <= '0;
            drem_reg <= '0;
            pdiv_reg <= (tilt_div == 16'd0) ? 16'd1 : tilt_div;
            ddiv_reg <= (rate_div == 16'd0) ? 16'd1 : rate_div;
        end
        if (cmd.div_step)
        begin
            if (!ptry[16])
            begin
                prem_reg <= ptry[15:0];
                pnum_reg <= {pnum_reg[21:0], 1'b1};
            end
            else
            begin
                prem_reg <= {prem_reg[14:0], pnum_reg[22]};
                pnum_reg <= {pnum_reg[21:0], 1'b0};
            end
            if (!dtry[16])
            begin
                drem_reg <= dtry[15:0];
                dnum_reg <= {dnum_reg[21:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[14:0], dnum_reg[22]};
                dnum_reg <= {dnum_reg[21:0], 1'b0};
            end
        end
        if (cmd.pd)
        begin
            drive_reg <= 7'(cmdsat);
        end
        if (cmd.bridge)
        begin
            tilt_hundredths <= tilt_reg;
            tilt_rate       <= rate_reg;
            drive           <= drive_reg;
            forward         <= !drive_reg[6];
            bridge_awake    <= (drive_reg != 7'sd0);
            if (drive_reg[6])
            begin
                compare_a <= pwm_full;
                compare_b <= red[18] ? 16'd0 : red[15:0];
            end
            else
            begin
                compare_a <= red[18] ? 16'd0 : red[15:0];
                compare_b <= pwm_full;
            end
        end
    end

endmodule

// ----- rtl/core/tbpd_config.sv -----
// ----------------------------------------------------------------------------
// Tilt balance configuration registers
// Write-only register file with reset values.
// ----------------------------------------------------------------------------
module tbpd_config import tbpd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic [15:0]        tilt_div,
    output logic [15:0]        rate_div,
    output logic signed [10:0] offset,
    output logic [15:0]        pwm_full,
    output logic [10:0]        pwm_step
);

    // Register writes decoded by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_div <= 16'd30;
            rate_div <= 16'd2000;
            offset   <= '0;
            pwm_full <= 16'd1000;
            pwm_step <= 11'd20;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TILT_DIV: tilt_div <= cfg_data;
                REG_RATE_DIV: rate_div <= cfg_data;
                REG_OFFSET:   offset   <= cfg_data[10:0];
                REG_PWM_FULL: pwm_full <= cfg_data;
                REG_PWM_STEP: pwm_step <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/tilt_balance_pd_bridge_drive.sv -----
// ----------------------------------------------------------------------------
// Tilt balance PD bridge drive
// Tilt estimation, complementary filter, PD law and H-bridge compare values.
// ----------------------------------------------------------------------------
// One IMU sample enters on the input channel when in_valid is high and
// in_stall low; one result leaves on the output channel when out_valid is
// high and out_stall low. Each transaction passes from acceptance to the
// result register through the CORDIC iterations followed by 23 steps of
// the serial dividers. One sample is processed at a time; a new one is
// accepted once the result has been moved to the output register. If the
// receiver stalls, the result is held and a finished following sample
// waits until the register frees.
// Reset clears the filter state, the previous tilt, the controller and
// loads the configuration registers with their default values.
// Configuration is written through cfg_write, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module tilt_balance_pd_bridge_drive import tbpd_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int TILT_LIMIT   = DEF_TILT_LIMIT,
    parameter int DRIVE_LIMIT  = DEF_DRIVE_LIMIT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] tilt_hundredths,
    output logic signed [22:0] tilt_rate,
    output logic signed [6:0]  drive,
    output logic        [15:0] compare_a,
    output logic        [15:0] compare_b,
    output logic               forward,
    output logic               bridge_awake
);

    tbpd_cmd_t          cmd;
    logic [15:0]        tilt_div, rate_div, pwm_full;
    logic signed [10:0] offset;
    logic [10:0]        pwm_step;

    tbpd_config u_config (
        .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
        .tilt_div, .rate_div, .offset, .pwm_full, .pwm_step
    );

    tbpd_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
    );

    tbpd_datapath #(.TILT_LIMIT(TILT_LIMIT), .DRIVE_LIMIT(DRIVE_LIMIT)) u_dp (
        .clk, .rst_n, .cmd, .accel_x, .accel_z, .gyro_y,
        .tilt_div, .rate_div, .offset, .pwm_full, .pwm_step,
        .tilt_hundredths, .tilt_rate, .drive, .compare_a, .compare_b,
        .forward, .bridge_awake
    );

    // A result never appears in the cycle after a sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result raised straight after acceptance");

    // Drive and wake agree
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bridge_awake == (drive != 7'sd0)))
        else $error("wake bit does not match drive");

    // Direction agrees with drive sign
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (forward == !drive[6]))
        else $error("direction bit does not match drive");

endmodule

// ----- dv/tilt_balance_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt balance checker
// Watches the sample, result and register channels of the tilt balance PD
// bridge drive, predicts each result from the accepted samples and compares
// the results in order, field by field.
// ----------------------------------------------------------------------------
module tilt_balance_checker import tbpd_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int TILT_LIMIT   = DEF_TILT_LIMIT,
    parameter int DRIVE_LIMIT  = DEF_DRIVE_LIMIT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] tilt_hundredths,
    input  logic signed [22:0] tilt_rate,
    input  logic signed [6:0]  drive,
    input  logic        [15:0] compare_a,
    input  logic        [15:0] compare_b,
    input  logic               forward,
    input  logic               bridge_awake,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] tilt;
        logic signed [22:0] rate;
        logic signed [6:0]  drv;
        logic        [15:0] cmp_a;
        logic        [15:0] cmp_b;
        logic               fwd;
        logic               awake;
    } bridge_result_t;

    // Rounded atan(2^-i) in 1/65536 degree
    localparam longint ATAN_DEG [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    bridge_result_t     awaited_results[$];
    logic        [15:0] p_divisor, d_divisor, full_count;
    logic signed [10:0] offset;
    logic        [10:0] step_count;
    logic signed [31:0] fused_angle;
    logic signed [15:0] last_tilt;

    assign pending = awaited_results.size();

    // Accelerometer angle in 1/65536 degree by vectoring CORDIC
    function automatic longint accel_angle(longint zv, longint xv);
        longint x, y, acc, nx;
        x = xv * 256;
        y = zv * 256;
        acc = 0;
        if (xv == 0 && zv == 0)
            return 0;
        if (x < 0)
        begin
            acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                acc += ATAN_DEG[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                acc -= ATAN_DEG[i];
            end
            x = nx;
        end
        return acc;
    endfunction

    // Advance the filter and PD law by one sample and queue the result
    task automatic predict_drive(longint ax, longint az, longint gy);
        longint acc_tilt, f, tilt, rate, cmd, lim, mag, red, dp, dd, ca, cb;
        bridge_result_t r;
        acc_tilt = (accel_angle(az, ax) * 25) >>> 6;
        f = (longint'(W_OLD) * (longint'(fused_angle) + (gy / 10) * 256)
             + longint'(W_NEW) * acc_tilt) >>> 16;
        fused_angle = f[31:0];
        tilt = f / 256;
        if (tilt > TILT_SAT) tilt = TILT_SAT;
        if (tilt < -TILT_SAT) tilt = -TILT_SAT;
        rate = (tilt - longint'(last_tilt)) * 100;
        last_tilt = tilt[15:0];
        dp = (p_divisor == 0) ? 1 : longint'(p_divisor);
        dd = (d_divisor == 0) ? 1 : longint'(d_divisor);
        cmd = 0;
        if ((tilt < 0 ? -tilt : tilt) < TILT_LIMIT)
            cmd = tilt / dp - rate / dd - longint'(offset);
        lim = DRIVE_LIMIT;
        if (lim > 63) lim = 63;
        if (lim < 0) lim = 0;
        if (cmd > lim) cmd = lim;
        if (cmd < -lim) cmd = -lim;
        mag = cmd < 0 ? -cmd : cmd;
        red = longint'(full_count) - longint'(step_count) * mag;
        if (red < 0) red = 0;
        ca = (cmd < 0) ? longint'(full_count) : red;
        cb = (cmd < 0) ? red : longint'(full_count);
        r.tilt  = tilt[15:0];
        r.rate  = rate[22:0];
        r.drv   = cmd[6:0];
        r.cmp_a = ca[15:0];
        r.cmp_b = cb[15:0];
        r.fwd   = (cmd >= 0);
        r.awake = (cmd != 0);
        awaited_results.push_back(r);
    endtask

    task automatic check_field(string label, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            errors++;
        end
    endtask

    // Register writes, sample transactions and result transactions
    always @(posedge clk or negedge rst_n)
    begin
        bridge_result_t w;
        if (!rst_n)
        begin
            p_divisor   = 16'd30;
            d_divisor   = 16'd2000;
            offset      = '0;
            full_count  = 16'd1000;
            step_count  = 11'd20;
            fused_angle = '0;
            last_tilt   = '0;
            awaited_results.delete();
            errors      = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TILT_DIV: p_divisor  = cfg_data;
                    REG_RATE_DIV: d_divisor  = cfg_data;
                    REG_OFFSET:   offset     = cfg_data[10:0];
                    REG_PWM_FULL: full_count = cfg_data;
                    REG_PWM_STEP: step_count = cfg_data[10:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result transaction with none expected, tilt %0d",
                             $time, tilt_hundredths);
                    errors++;
                end
                else
                begin
                    w = awaited_results.pop_front();
                    check_field("tilt_hundredths", w.tilt, tilt_hundredths);
                    check_field("tilt_rate", w.rate, tilt_rate);
                    check_field("drive", w.drv, drive);
                    check_field("compare_a", w.cmp_a, compare_a);
                    check_field("compare_b", w.cmp_b, compare_b);
                    check_field("forward", w.fwd, forward);
                    check_field("bridge_awake", w.awake, bridge_awake);
                end
            end
            if (in_valid && !in_stall)
                predict_drive(accel_x, accel_z, gyro_y);
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt balance PD bridge drive testbench
// Drives directed and random IMU samples under several register settings and
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import tbpd_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 5000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] accel_x, accel_z, gyro_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] tilt_hundredths;
    logic signed [22:0] tilt_rate;
    logic signed [6:0]  drive;
    logic        [15:0] compare_a, compare_b;
    logic               forward, bridge_awake;
    int                 errors, pending;
    int                 send_idle_pct, recv_idle_pct;
    int                 quiet_cycles;

    tilt_balance_pd_bridge_drive u_dut (.*);
    tilt_balance_checker u_checker (.*);

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(logic [15:0] ax, logic [15:0] az, logic [15:0] gy);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= ax;
        accel_z  <= az;
        gyro_y   <= gy;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Hold off until every result is back and the block has gone quiet
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(int sel);
        case (sel)
            0:
            begin
                write_reg(REG_TILT_DIV, 16'd30);
                write_reg(REG_RATE_DIV, 16'd2000);
                write_reg(REG_OFFSET, 16'd0);
                write_reg(REG_PWM_FULL, 16'd1000);
                write_reg(REG_PWM_STEP, 16'd20);
            end
            1:
            begin
                write_reg(REG_TILT_DIV, 16'd0);
                write_reg(REG_RATE_DIV, 16'd1);
                write_reg(REG_OFFSET, 16'(-1000));
                write_reg(REG_PWM_FULL, 16'd65535);
                write_reg(REG_PWM_STEP, 16'd1310);
            end
            2:
            begin
                write_reg(REG_TILT_DIV, 16'd65535);
                write_reg(REG_RATE_DIV, 16'd65535);
                write_reg(REG_OFFSET, 16'd1000);
                write_reg(REG_PWM_FULL, 16'd0);
                write_reg(REG_PWM_STEP, 16'd0);
            end
            3:
            begin
                write_reg(REG_TILT_DIV, 16'd1);
                write_reg(REG_RATE_DIV, 16'd0);
                write_reg(REG_OFFSET, 16'h0400);
                write_reg(REG_PWM_FULL, 16'd500);
                write_reg(REG_PWM_STEP, 16'h07FF);
            end
            default:
            begin
                write_reg(REG_TILT_DIV, 16'($urandom_range(1, 400)));
                write_reg(REG_RATE_DIV, 16'($urandom_range(1, 5000)));
                write_reg(REG_OFFSET, 16'($urandom_range(0, 40)) - 16'd20);
                write_reg(REG_PWM_FULL, 16'($urandom_range(0, 65535)));
                write_reg(REG_PWM_STEP, 16'($urandom_range(0, 1310)));
            end
        endcase
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] gy;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        accel_x = '0;
        accel_z = '0;
        gyro_y = '0;
        out_stall = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 20;
        recv_idle_pct = 70;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, field extremes and every quadrant but negative x with positive z
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'd0, 16'd0);
        send_sample(16'h8000, 16'hFFFF, 16'd0);
        send_sample(16'd1, 16'h8000, 16'd9);
        send_sample(16'd0, 16'h7FFF, 16'hFFF7);
        // Gyro held at its extremes drives the tilt into saturation and back
        repeat (9) send_sample(16'd0, 16'd100, 16'h7FFF);
        repeat (9) send_sample(16'd0, 16'hFF9C, 16'h8000);
        drain();

        // Random: three idling regimes, register setting changed per block
        for (int blk = 0; blk < 12; blk++)
        begin
            if (blk == 4)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 20;
            end
            if (blk == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_setting(blk % 6);
            repeat (100)
            begin
                // Mostly gentle gyro keeps the tilt where the PD law is active
                if ($urandom_range(9) < 7)
                    gy = 16'($urandom_range(0, 1600)) - 16'd800;
                else
                    gy = 16'($urandom);
                send_sample(16'($urandom), 16'($urandom), gy);
            end
            drain();
        end

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- tilt_balance_pd_bridge_drive.f -----
rtl/core/tbpd_pkg.sv
rtl/core/tbpd_ctrl.sv
rtl/core/tbpd_datapath.sv
rtl/core/tbpd_config.sv
rtl/core/tilt_balance_pd_bridge_drive.sv
dv/tilt_balance_checker.sv
dv/testbench.sv
